@@ hw/rtl/pdc_pkg.sv @@
package pdc_pkg;

	// Packet framing
	localparam int HDR_WORD_BYTES = 8;
	localparam int HDR_BYTES      = 12;
	localparam int CRC_BYTES      = 4;
	localparam int MAX_PAYLOAD    = 512;
	localparam int TRUNC_BIT      = 5;

	localparam logic [1:0] TYPE_DATA = 2'd1;
	localparam logic [1:0] TYPE_NONE = 2'd0;

	// Byte position counter, saturating
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Position compares are done on a width that holds count + 16-bit length
	localparam int POS_W = 17;

	// CRC-32, reflected
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam logic [FIFO_CW-1:0] FIFO_ROOM_LIMIT = FIFO_CW'(FIFO_DEPTH - 2);

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_SHORT        = 3'd1,
		ST_BAD_TYPE     = 3'd2,
		ST_BAD_TRUNC    = 3'd3,
		ST_BAD_LENGTH   = 3'd4,
		ST_BAD_CRC      = 3'd5,
		ST_INCONSISTENT = 3'd6
	} pdc_status_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		pdc_status_t status;
		logic [1:0]  packet_type;
		logic        trunc_flag;
		logic [4:0]  window_size;
		logic [7:0]  seq_number;
		logic [15:0] payload_length;
		logic [31:0] time_stamp;
	} pdc_result_t;

	// Up to two results leave the parser per byte; b is only valid with a
	typedef struct packed {
		logic        valid_a;
		logic        valid_b;
		pdc_result_t res_a;
		pdc_result_t res_b;
	} pdc_push_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ hw/rtl/pdc_parser.sv @@
module pdc_parser
	import pdc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       room,
	output pdc_push_t  push
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               last_s1;
	logic               advance;

	logic [COUNT_W-1:0] byte_count_q;
	logic [63:0]        header_q;
	logic [31:0]        hcrc_recv_q;
	logic [31:0]        hcrc_run_q;
	logic [31:0]        pcrc_q;
	logic [31:0]        trailer_q;

	logic [COUNT_W-1:0] count_n;
	logic [63:0]        header_n;
	logic [31:0]        hcrc_recv_n;
	logic [31:0]        hcrc_run_n;
	logic [31:0]        pcrc_n;
	logic [31:0]        trailer_n;
	logic [15:0]        len_q;
	logic               is_payload;
	logic [7:0]         hcrc_in;
	pdc_status_t        status;
	pdc_result_t        pay_res;
	pdc_result_t        st_res;

	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// Length as seen before the current byte lands in the header
	assign len_q = {header_q[23:16], header_q[31:24]};

	always_comb begin
		header_n    = header_q;
		hcrc_recv_n = hcrc_recv_q;
		hcrc_run_n  = hcrc_run_q;
		pcrc_n      = pcrc_q;
		trailer_n   = trailer_q;
		is_payload  = 1'b0;
		hcrc_in     = byte_s1;
		if (byte_count_q == '0) begin
			hcrc_in[TRUNC_BIT] = 1'b0;
		end
		if (byte_count_q < COUNT_W'(HDR_WORD_BYTES)) begin
			for (int i = 0; i < HDR_WORD_BYTES; i++) begin
				if (byte_count_q[2:0] == 3'(i)) begin
					header_n[8*i +: 8] = byte_s1;
				end
			end
			hcrc_run_n = crc32_byte(hcrc_run_q, hcrc_in);
		end else if (byte_count_q < COUNT_W'(HDR_BYTES)) begin
			hcrc_recv_n = {hcrc_recv_q[23:0], byte_s1};
		end else if (POS_W'(byte_count_q) < POS_W'(HDR_BYTES) + POS_W'(len_q)) begin
			is_payload = 1'b1;
			pcrc_n     = crc32_byte(pcrc_q, byte_s1);
		end else begin
			trailer_n = {trailer_q[23:0], byte_s1};
		end
		count_n = (byte_count_q == COUNT_MAX) ? byte_count_q : byte_count_q + 1'b1;
	end

	// End-of-packet status, first failing check wins
	always_comb begin
		if (count_n < COUNT_W'(HDR_BYTES)) begin
			status = ST_SHORT;
		end else if (header_n[7:6] == TYPE_NONE) begin
			status = ST_BAD_TYPE;
		end else if (header_n[TRUNC_BIT] && (header_n[7:6] != TYPE_DATA
				|| count_n != COUNT_W'(HDR_BYTES))) begin
			status = ST_BAD_TRUNC;
		end else if (len_q > 16'(MAX_PAYLOAD)) begin
			status = ST_BAD_LENGTH;
		end else if (~hcrc_run_n != hcrc_recv_n) begin
			status = ST_BAD_CRC;
		end else if (count_n == COUNT_W'(HDR_BYTES)) begin
			status = ST_OK;
		end else if (POS_W'(count_n) != POS_W'(HDR_BYTES + CRC_BYTES) + POS_W'(len_q)) begin
			status = ST_INCONSISTENT;
		end else if (len_q == '0) begin
			status = ST_INCONSISTENT;
		end else if (~pcrc_q != trailer_n) begin
			status = ST_BAD_CRC;
		end else begin
			status = ST_OK;
		end
	end

	always_comb begin
		pay_res              = '0;
		pay_res.kind         = KIND_PAYLOAD;
		pay_res.payload_byte = byte_s1;
		pay_res.status       = ST_OK;

		st_res                = '0;
		st_res.kind           = KIND_STATUS;
		st_res.status         = status;
		st_res.packet_type    = header_n[7:6];
		st_res.trunc_flag     = header_n[TRUNC_BIT];
		st_res.window_size    = header_n[4:0];
		st_res.seq_number     = header_n[15:8];
		st_res.payload_length = len_q;
		st_res.time_stamp     = header_n[63:32];

		push.valid_a = advance && (is_payload || last_s1);
		push.valid_b = advance && is_payload && last_s1;
		push.res_a   = is_payload ? pay_res : st_res;
		push.res_b   = st_res;
	end

	// Packet state: advance on each byte, return to reset after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			header_q     <= '0;
			hcrc_recv_q  <= '0;
			hcrc_run_q   <= CRC_INIT;
			pcrc_q       <= CRC_INIT;
			trailer_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				byte_count_q <= '0;
				header_q     <= '0;
				hcrc_recv_q  <= '0;
				hcrc_run_q   <= CRC_INIT;
				pcrc_q       <= CRC_INIT;
				trailer_q    <= '0;
			end else begin
				byte_count_q <= count_n;
				header_q     <= header_n;
				hcrc_recv_q  <= hcrc_recv_n;
				hcrc_run_q   <= hcrc_run_n;
				pcrc_q       <= pcrc_n;
				trailer_q    <= trailer_n;
			end
		end
	end

endmodule

@@ hw/rtl/pdc_res_fifo.sv @@
module pdc_res_fifo
	import pdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  pdc_push_t   push,
	output logic        room,
	output logic        out_valid,
	input  logic        out_ready,
	output pdc_result_t out_res
);

	pdc_result_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;
	logic [FIFO_CW-1:0] n_push;
	logic [FIFO_AW-1:0] wr_ptr_b;

	// Keep space for a two-result push without looking at the pop
	assign room      = count_q <= FIFO_ROOM_LIMIT;
	assign out_valid = count_q != '0;
	assign out_res   = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = FIFO_CW'(push.valid_a) + FIFO_CW'(push.valid_b);
	assign wr_ptr_b  = wr_ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push.valid_a) begin
			mem_q[wr_ptr_q] <= push.res_a;
		end
		if (push.valid_b) begin
			mem_q[wr_ptr_b] <= push.res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + n_push - FIFO_CW'(pop);
		end
	end

endmodule

@@ hw/rtl/packet_deframe_crc_check_core.sv @@
// Packet deframer with CRC-32 checks. Wire bytes enter one beat at a time on the
// s_ side, tlast on the final byte of a packet. The first 12 bytes are the header
// (type/trunc/window, seqnum, big-endian length, timestamp with the first byte
// least significant, big-endian header CRC-32 over bytes 0..7 with the trunc bit
// cleared); the next "length" bytes are payload and leave on the m_ side as
// payload beats (tuser 0) as soon as they are seen, and the rest form the
// big-endian payload CRC-32. After the last byte one status beat (tuser 1)
// carries the verdict and the header fields, and the block is ready for the next
// packet with no gap. Throughput is one byte per clock while the queue has
// room: each byte is held in the input register, the parser updates the header
// and payload CRCs with a single byte-wide CRC-32 step, and the results drop
// into a four-beat queue, so a result passes the input register and the queue
// before it is offered on m_. A last byte that is also payload makes two beats;
// the queue then drains at one beat per cycle while m_tready is high, and
// s_tready drops while more than two beats wait and a byte is held. m_tready
// low holds results in the queue and, once it fills, stalls the input.
module packet_deframe_crc_check_core
	import pdc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // is_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [7:0] payload_byte, [10:8] status, [12:11] packet_type,
	                               // [13] trunc_flag, [18:14] window_size, [26:19] seq_number,
	                               // [42:27] payload_length, [74:43] time_stamp, [79:75] zero
	output logic        m_tuser    // kind: 0 payload beat, 1 status beat
);

	pdc_push_t   push;
	logic        room;
	pdc_result_t res;

	// Input register, header/payload parsing and end-of-packet checks
	pdc_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.room     (room),
		.push     (push)
	);

	// Result queue decouples the output handshake from the parser
	pdc_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tuser = res.kind;
	assign m_tdata = {5'd0, res.time_stamp, res.payload_length, res.seq_number,
		res.window_size, res.trunc_flag, res.packet_type, res.status, res.payload_byte};

endmodule

@@ hw/rtl/pdc_checker.sv @@
module pdc_checker
	import pdc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata,
	input logic        m_tuser
);

	// A stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	// Payload beats carry only the byte
	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_PAYLOAD |-> m_tdata[79:8] == '0)
		else $error("payload beat carries header fields");

	// An ok packet has a type and a length within limit
	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATUS && m_tdata[10:8] == ST_OK
		|-> m_tdata[12:11] != TYPE_NONE && m_tdata[42:27] <= 16'(MAX_PAYLOAD))
		else $error("ok status with bad type or length");

	// Truncated packets only pass as data packets
	a_ok_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_STATUS && m_tdata[10:8] == ST_OK && m_tdata[13]
		|-> m_tdata[12:11] == TYPE_DATA)
		else $error("ok status on truncated non-data packet");

endmodule

bind packet_deframe_crc_check_core pdc_checker u_pdc_checker (.*);

@@ tb/packet_deframe_crc_check_core_test.sv @@
`timescale 1ns / 100ps

module packet_deframe_crc_check_core_test;
	import pdc_pkg::*;

	localparam int RANDOM_BYTES = 300;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'd0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [79:0] m_tdata;
	logic        m_tuser;

	packet_deframe_crc_check_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Shadow of the deframer state
	logic [10:0] pos_count   = '0;
	logic [63:0] hdr_word    = '0;
	logic [31:0] hdr_crc_rx  = '0;
	logic [31:0] pay_crc     = CRC_INIT;
	logic [31:0] trl_crc_rx  = '0;

	pdc_result_t pending_results[$];
	pdc_result_t want_beat;
	logic [7:0]  pkt[$];

	int mismatch_count  = 0;
	int bytes_sent      = 0;
	int packets_sent    = 0;
	int payload_checked = 0;
	int status_checked  = 0;
	int status_hist[7];

	// Sender and receiver pacing
	bit tx_calm       = 1'b0;
	bit tx_burst      = 1'b0;
	int tx_phase_left = 0;
	bit rx_calm       = 1'b0;
	int rx_phase_left = 0;
	int rx_gap        = 0;
	int hold_req      = 0;
	int hold_left     = 0;

	function automatic logic [31:0] crc_byte_step(input logic [31:0] crc, input logic [7:0] d);
		logic [31:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ d[i];
			c  = c >> 1;
			if (fb)
				c = c ^ 32'hEDB8_8320;
		end
		return c;
	endfunction

	// Mostly no gap, some short ones, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 8);
		return $urandom_range(20, 50);
	endfunction

	// Work out the results one wire byte causes and queue them
	task automatic predict_byte(input logic [7:0] b, input logic last);
		int          pos;
		int          len;
		int          total;
		logic [7:0]  b0;
		logic [31:0] hcrc;
		logic [1:0]  ptype;
		logic        trunc;
		pdc_status_t st;
		pdc_result_t r;
		pos = pos_count;
		len = {hdr_word[23:16], hdr_word[31:24]};
		if (pos < HDR_WORD_BYTES) begin
			hdr_word[8*pos +: 8] = b;
		end else if (pos < HDR_BYTES) begin
			hdr_crc_rx = {hdr_crc_rx[23:0], b};
		end else if (pos < HDR_BYTES + len) begin
			r = '0;
			r.kind = KIND_PAYLOAD;
			r.payload_byte = b;
			pending_results.push_back(r);
			pay_crc = crc_byte_step(pay_crc, b);
		end else begin
			trl_crc_rx = {trl_crc_rx[23:0], b};
		end
		if (pos_count != COUNT_MAX)
			pos_count++;
		if (last) begin
			total = pos_count;
			b0    = hdr_word[7:0];
			ptype = b0[7:6];
			trunc = b0[TRUNC_BIT];
			hcrc  = CRC_INIT;
			for (int i = 0; i < HDR_WORD_BYTES; i++)
				hcrc = crc_byte_step(hcrc, (i == 0) ? (b0 & 8'hDF) : hdr_word[8*i +: 8]);
			hcrc = ~hcrc;
			if (total < HDR_BYTES)
				st = ST_SHORT;
			else if (ptype == TYPE_NONE)
				st = ST_BAD_TYPE;
			else if (trunc && ptype != TYPE_DATA)
				st = ST_BAD_TRUNC;
			else if (trunc && total != HDR_BYTES)
				st = ST_BAD_TRUNC;
			else if (len > MAX_PAYLOAD)
				st = ST_BAD_LENGTH;
			else if (hcrc != hdr_crc_rx)
				st = ST_BAD_CRC;
			else if (total == HDR_BYTES)
				st = ST_OK;
			else if (total != HDR_BYTES + len + CRC_BYTES)
				st = ST_INCONSISTENT;
			else if (len == 0)
				st = ST_INCONSISTENT;
			else if (~pay_crc != trl_crc_rx)
				st = ST_BAD_CRC;
			else
				st = ST_OK;
			r = '0;
			r.kind           = KIND_STATUS;
			r.status         = st;
			r.packet_type    = ptype;
			r.trunc_flag     = trunc;
			r.window_size    = b0[4:0];
			r.seq_number     = hdr_word[15:8];
			r.payload_length = len[15:0];
			r.time_stamp     = hdr_word[63:32];
			pending_results.push_back(r);
			status_hist[int'(st)]++;
			pos_count  = '0;
			hdr_word   = '0;
			hdr_crc_rx = '0;
			pay_crc    = CRC_INIT;
			trl_crc_rx = '0;
		end
	endtask

	// Offer one beat after a random gap and hold it until taken
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (tx_phase_left == 0) begin
			tx_calm       = ($urandom_range(0, 3) == 0);
			tx_phase_left = $urandom_range(20, 200);
		end else begin
			tx_phase_left--;
		end
		gap = (tx_calm || tx_burst) ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_packet();
		foreach (pkt[i])
			send_byte(pkt[i], i == pkt.size() - 1);
		packets_sent++;
	endtask

	// Header, n_pay payload bytes (fill < 0 means random) and an optional trailer CRC
	task automatic build_packet(input logic [7:0] b0, input logic [7:0] seq,
	                            input logic [15:0] len, input logic [31:0] ts,
	                            input int n_pay, input bit with_trailer, input int fill);
		logic [31:0] c;
		logic [7:0]  d;
		pkt.delete();
		pkt.push_back(b0);
		pkt.push_back(seq);
		pkt.push_back(len[15:8]);
		pkt.push_back(len[7:0]);
		for (int i = 0; i < 4; i++)
			pkt.push_back(ts[8*i +: 8]);
		c = CRC_INIT;
		for (int i = 0; i < HDR_WORD_BYTES; i++)
			c = crc_byte_step(c, (i == 0) ? (b0 & 8'hDF) : pkt[i]);
		c = ~c;
		for (int i = 3; i >= 0; i--)
			pkt.push_back(c[8*i +: 8]);
		c = CRC_INIT;
		for (int i = 0; i < n_pay; i++) begin
			d = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
			pkt.push_back(d);
			c = crc_byte_step(c, d);
		end
		c = ~c;
		if (with_trailer)
			for (int i = 3; i >= 0; i--)
				pkt.push_back(c[8*i +: 8]);
	endtask

	// Drop valid and hold until every queued result has been seen
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// Receiver: random gaps, calm stretches, and a long hold-off on request
	always @(posedge clk) begin
		if (rx_phase_left == 0) begin
			rx_calm       = ($urandom_range(0, 3) == 0);
			rx_phase_left = $urandom_range(50, 300);
		end else begin
			rx_phase_left--;
		end
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap != 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (!rx_calm)
				rx_gap = pick_gap();
		end
	end

	// Compare each taken result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual tuser %0d tdata %0h",
				         $time, m_tuser, m_tdata);
				mismatch_count++;
			end else begin
				want_beat = pending_results.pop_front();
				check_field("kind",           32'(want_beat.kind),           32'(m_tuser));
				check_field("payload_byte",   32'(want_beat.payload_byte),   32'(m_tdata[7:0]));
				check_field("status",         32'(want_beat.status),         32'(m_tdata[10:8]));
				check_field("packet_type",    32'(want_beat.packet_type),    32'(m_tdata[12:11]));
				check_field("trunc_flag",     32'(want_beat.trunc_flag),     32'(m_tdata[13]));
				check_field("window_size",    32'(want_beat.window_size),    32'(m_tdata[18:14]));
				check_field("seq_number",     32'(want_beat.seq_number),     32'(m_tdata[26:19]));
				check_field("payload_length", 32'(want_beat.payload_length), 32'(m_tdata[42:27]));
				check_field("time_stamp",     want_beat.time_stamp,          m_tdata[74:43]);
				check_field("tdata_pad",      32'd0,                         32'(m_tdata[79:75]));
				if (want_beat.kind == KIND_STATUS)
					status_checked++;
				else
					payload_checked++;
			end
		end
	end

	task automatic test_reset();
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	task automatic test_directed_frames();
		// header only with the trunc flag on a data packet; the flag is excluded from the CRC
		build_packet(8'h7F, 8'hFF, 16'd0, 32'hFFFF_FFFF, 0, 0, -1);
		send_packet();
		// single byte, then eleven bytes: both short
		pkt.delete();
		pkt.push_back(8'hFF);
		send_packet();
		build_packet(8'h40, 8'h00, 16'd3, 32'd0, 3, 1, -1);
		while (pkt.size() > 11)
			void'(pkt.pop_back());
		send_packet();
		// type zero
		build_packet(8'h1F, 8'h01, 16'd4, 32'h1234_5678, 4, 1, -1);
		send_packet();
		// trunc flag on a non-data type, and on a data packet with payload
		build_packet(8'hA0, 8'h02, 16'd0, 32'd0, 0, 0, -1);
		send_packet();
		build_packet(8'h60, 8'h03, 16'd3, 32'd0, 3, 1, -1);
		send_packet();
		// length above the limit
		build_packet(8'h40, 8'h04, 16'd513, 32'd0, 0, 0, -1);
		send_packet();
		build_packet(8'h40, 8'h05, 16'hFFFF, 32'd0, 0, 0, -1);
		send_packet();
		// corrupted header CRC
		build_packet(8'h45, 8'h06, 16'd2, 32'hDEAD_BEEF, 2, 1, -1);
		pkt[11] ^= 8'h01;
		send_packet();
		// header only on a plain data packet with a nonzero length field
		build_packet(8'h40, 8'h07, 16'd5, 32'd0, 0, 0, -1);
		send_packet();
		// one trailer byte missing
		build_packet(8'h81, 8'h08, 16'd5, 32'd7, 5, 1, -1);
		void'(pkt.pop_back());
		send_packet();
		// zero length with a trailer
		build_packet(8'hC0, 8'h09, 16'd0, 32'd9, 0, 1, -1);
		send_packet();
		// corrupted payload CRC
		build_packet(8'h5A, 8'h0A, 16'd6, 32'd10, 6, 1, -1);
		pkt[pkt.size() - 1] ^= 8'h80;
		send_packet();
		// good frames: one byte of all ones, and the largest payload of zeros
		build_packet(8'hDF, 8'hFF, 16'd1, 32'hFFFF_FFFF, 1, 1, 8'hFF);
		send_packet();
		build_packet(8'h40, 8'h00, 16'd512, 32'd0, 512, 1, 0);
		send_packet();
		// last byte is still payload: payload beat then status beat
		build_packet(8'h41, 8'h0B, 16'd10, 32'd11, 10, 1, -1);
		repeat (8) void'(pkt.pop_back());
		send_packet();
		// all-zero frame
		pkt.delete();
		repeat (16) pkt.push_back(8'h00);
		send_packet();
		// runs past the saturating byte counter
		build_packet(8'h40, 8'h0C, 16'd512, 32'd12, 512, 1, -1);
		repeat (1530) pkt.push_back(8'($urandom_range(0, 255)));
		send_packet();
		wait_drained();
	endtask

	task automatic test_random_frames();
		int         start_bytes;
		int         r;
		int         len;
		int         n;
		logic [1:0] ptype;
		logic [7:0] b0;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			ptype = 2'($urandom_range(1, 3));
			b0    = {ptype, 1'b0, 5'($urandom_range(0, 31))};
			r     = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(1, 24);
			else if (r < 85)
				len = 0;
			else if (r < 97)
				len = $urandom_range(25, 100);
			else
				len = $urandom_range(400, 512);
			if (len == 0 && $urandom_range(0, 1) == 1)
				b0 = {TYPE_DATA, 1'b1, b0[4:0]};
			build_packet(b0, 8'($urandom_range(0, 255)), 16'(len), $urandom, len, len != 0, -1);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// well-formed
			end else if (r < 80) begin
				n = $urandom_range(0, pkt.size() - 1);
				pkt[n] ^= 8'(1 << $urandom_range(0, 7));
			end else if (r < 86) begin
				n = $urandom_range(1, pkt.size() - 1);
				repeat (n) void'(pkt.pop_back());
			end else if (r < 90) begin
				repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom_range(0, 255)));
			end else if (r < 94) begin
				// random header byte 0 and length field, body unchanged
				pkt[0] = 8'($urandom_range(0, 255));
				pkt[2] = 8'($urandom_range(0, 255));
				pkt[3] = 8'($urandom_range(0, 255));
			end else begin
				pkt.delete();
				repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom_range(0, 255)));
			end
			send_packet();
			// pause the sender now and then until the block has emptied
			if ($urandom_range(0, 11) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		@(negedge clk);
		hold_req = 400;
		@(posedge clk);
		tx_burst = 1'b1;
		repeat (3) begin
			build_packet(8'h4A, 8'($urandom_range(0, 255)), 16'd40, $urandom, 40, 1, -1);
			send_packet();
		end
		tx_burst = 1'b0;
		wait_drained();
	endtask

	initial begin
		test_reset();
		test_directed_frames();
		test_backpressure();
		test_random_frames();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("covered %0d packets, %0d wire bytes; checked %0d payload and %0d status beats",
		         packets_sent, bytes_sent, payload_checked, status_checked);
		$display("statuses ok %0d short %0d type %0d trunc %0d length %0d crc %0d size %0d",
		         status_hist[0], status_hist[1], status_hist[2], status_hist[3],
		         status_hist[4], status_hist[5], status_hist[6]);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("packet_deframe_crc_check_core regression: pass");
		else
			$display("packet_deframe_crc_check_core regression: fail");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("packet_deframe_crc_check_core regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/pdc_pkg.sv
hw/rtl/pdc_parser.sv
hw/rtl/pdc_res_fifo.sv
hw/rtl/packet_deframe_crc_check_core.sv
hw/rtl/pdc_checker.sv
tb/packet_deframe_crc_check_core_test.sv
